// ===== hw/rtl/stepper_ramp_pulse_scheduler_macros.svh =====
// Assertion macros shared by the stepper ramp scheduler RTL.
`ifndef STEPPER_RAMP_PULSE_SCHEDULER_MACROS_SVH
`define STEPPER_RAMP_PULSE_SCHEDULER_MACROS_SVH

`ifndef SYNTHESIS

`define SRPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srps assertion failed");

`define SRPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srps assertion failed");

`else

`define SRPS_ASSERT_NOW(label, clk, rst_n, ante, cons)

`define SRPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/srps_pkg.sv =====
// Types and constants of the stepper ramp pulse scheduler.
`timescale 1ns / 1ps

package srps_pkg;

    localparam int COUNT_BITS_DEF = 23;
    localparam int PULSE_BITS_DEF = 24;
    localparam int MOVE_BITS      = 24;
    localparam int RATE_BITS      = 16;
    localparam int FRS_BITS       = 23;
    localparam int CFG_PUL_BITS   = 24;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 24;

    localparam logic [RATE_BITS-1:0]    RST_ACCEL  = 16'd1000;
    localparam logic [RATE_BITS-1:0]    RST_DECEL  = 16'd1000;
    localparam logic [CFG_PUL_BITS-1:0] RST_C0     = 24'd1000;
    localparam logic [CFG_PUL_BITS-1:0] RST_CRUISE = 24'd1000;

    typedef enum logic [2:0] {
        FN_START = 3'd0,
        FN_STEP  = 3'd1,
        FN_ALTER = 3'd2,
        FN_BRAKE = 3'd3,
        FN_STOP  = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_ACCEL  = 3'd1,
        REG_DECEL  = 3'd2,
        REG_FRS    = 3'd3,
        REG_C0     = 3'd4,
        REG_CRUISE = 3'd5
    } t_cfg_reg;

    typedef enum logic [1:0] {
        MS_STOPPED = 2'd0,
        MS_ACCEL   = 2'd1,
        MS_CRUISE  = 2'd2,
        MS_DECEL   = 2'd3
    } t_mstate;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_MUL  = 3'd1,
        ST_LOAD = 3'd2,
        ST_DIV  = 3'd3,
        ST_ADV  = 3'd4,
        ST_DONE = 3'd5
    } t_state;

    typedef enum logic [2:0] {
        OP_PLAN1 = 3'd0,
        OP_PLAN2 = 3'd1,
        OP_BRAKE = 3'd2,
        OP_REC1  = 3'd3,
        OP_REC2  = 3'd4
    } t_op;

    typedef struct packed {
        logic start;
        logic done;
    } t_div_hs;

endpackage

// ===== hw/rtl/srps_div.sv =====
// Bit-serial restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module srps_div import srps_pkg::*; #(
    parameter int NB = 39,
    parameter int DB = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NB-1:0] i_dividend,
    input  logic [DB-1:0] i_divisor,
    output logic          o_done,
    output logic [NB-1:0] o_quotient,
    output logic [DB-1:0] o_remainder
);

    localparam int CW = $clog2(NB + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [NB-1:0] r_q, n_q;
    logic [DB-1:0] r_rem, n_rem;
    logic [DB-1:0] r_div, n_div;
    logic [DB:0]   w_sh;
    logic [DB:0]   w_diff;
    t_div_hs       w_hs;

    assign w_sh   = {r_rem, r_q[NB-1]};
    assign w_diff = w_sh - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(NB);
            n_q    = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            // The trial subtraction decides one quotient bit.
            if (!w_diff[DB]) begin
                n_rem = w_diff[DB-1:0];
                n_q   = {r_q[NB-2:0], 1'b1};
            end else begin
                n_rem = w_sh[DB-1:0];
                n_q   = {r_q[NB-2:0], 1'b0};
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    always_comb begin
        w_hs.start = i_start;
        w_hs.done  = r_done;
    end

    assign o_done      = w_hs.done;
    assign o_quotient  = r_q;
    assign o_remainder = r_rem;

endmodule

// ===== hw/rtl/stepper_ramp_pulse_scheduler.sv =====
// Top level of the stepper move planner and step interval generator.
`timescale 1ns / 1ps
`include "stepper_ramp_pulse_scheduler_macros.svh"

// One word in gives one word out. Start, alter and brake plan or trim a move;
// each step word returns the interval to wait before the next step and then
// advances the interval by the integer Austin recurrence. Words are handled
// one at a time. Stop, a cruise brake, a constant speed step and a simple
// alter use neither the multiplier nor the divider. A ramp start and a brake
// while accelerating form one product and one quotient; a ramp start whose
// move is too short for the full ramp forms two of each. A ramp step forms
// two quotients. The bit-serial divider is NB = max(COUNT_BITS + 16, 35)
// bits long and gives one quotient bit a cycle. Products are formed by a
// serial shift-add. A finished word waits in the output register while the
// next word is accepted.
module stepper_ramp_pulse_scheduler import srps_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int PULSE_BITS = PULSE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [2:0]               i_func,
    input  logic [MOVE_BITS-1:0]     i_move_steps,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [PULSE_BITS-1:0]    o_interval,
    output logic                     o_step_issued,
    output logic                     o_direction,
    output logic [1:0]               o_motion_state,
    output logic [COUNT_BITS-1:0]    o_steps_left,
    output logic [COUNT_BITS-1:0]    o_steps_dropped,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int NB = (COUNT_BITS + 16 > 35) ? COUNT_BITS + 16 : 35;
    localparam int DB = (COUNT_BITS + 2 > 17) ? COUNT_BITS + 2 : 17;
    localparam logic [31:0] CNT_LIM = (32'd1 << COUNT_BITS) - 32'd1;
    localparam logic [32:0] PUL_LIM = (33'd1 << PULSE_BITS) - 33'd1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = CNT_LIM[COUNT_BITS-1:0];
    localparam logic [PULSE_BITS-1:0] PUL_MAX = PUL_LIM[PULSE_BITS-1:0];
    localparam logic [4:0] MUL_STEPS = 5'(RATE_BITS);

    // Configuration registers.
    logic                    r_mode;
    logic [RATE_BITS-1:0]    r_accel, r_decel;
    logic [FRS_BITS-1:0]     r_frs;
    logic [CFG_PUL_BITS-1:0] r_c0, r_cruise;

    t_state                  r_state, n_state;
    t_op                     r_op, n_op;
    logic [COUNT_BITS-1:0]   r_remaining, n_remaining;
    logic [COUNT_BITS-1:0]   r_taken, n_taken;
    logic [COUNT_BITS-1:0]   r_up, n_up;
    logic [COUNT_BITS-1:0]   r_down, n_down;
    logic [PULSE_BITS-1:0]   r_pulse, n_pulse;
    logic [31:0]             r_carry, n_carry;
    logic                    r_dir, n_dir;
    logic [PULSE_BITS-1:0]   r_interval, n_interval;
    logic                    r_issued, n_issued;
    logic [COUNT_BITS-1:0]   r_dropped, n_dropped;
    logic [COUNT_BITS+15:0]  r_mul_acc, n_mul_acc;
    logic [COUNT_BITS-1:0]   r_mul_cand, n_mul_cand;
    logic [4:0]              r_cnt, n_cnt;
    logic [NB-1:0]           r_div_n, n_div_n;
    logic [DB-1:0]           r_div_d, n_div_d;
    logic                    r_div_go, n_div_go;
    logic                    r_nneg, n_nneg;
    logic                    r_dneg, n_dneg;
    logic                    r_out_valid, n_out_valid;
    logic [PULSE_BITS-1:0]   r_out_interval, n_out_interval;
    logic                    r_out_issued, n_out_issued;
    logic                    r_out_dir, n_out_dir;
    t_mstate                 r_out_ms, n_out_ms;
    logic [COUNT_BITS-1:0]   r_out_left, n_out_left;
    logic [COUNT_BITS-1:0]   r_out_dropped, n_out_dropped;

    logic [RATE_BITS-1:0]    w_a, w_d;
    t_mstate                 w_st;
    logic [24:0]             w_mag25;
    logic [COUNT_BITS-1:0]   w_mag;
    logic [COUNT_BITS-1:0]   w_frs_sat;
    logic [COUNT_BITS:0]     w_mul_sum;
    logic [NB:0]             w_num;
    logic [NB-1:0]           w_num_mag;
    logic [NB+1:0]           w_np_raw;
    logic [PULSE_BITS-1:0]   w_np;
    logic [COUNT_BITS-1:0]   w_q_sat;
    logic [31:0]             w_rem_clamp;
    logic                    w_div_done;
    logic [NB-1:0]           w_quot;
    logic [DB-1:0]           w_rmd;
    logic [32:0]             w_sum33;

    function automatic logic [PULSE_BITS-1:0] sat_pul(input logic [CFG_PUL_BITS-1:0] v);
        logic [32:0] vw;
        vw = 33'(v);
        if (vw > PUL_LIM) return PUL_MAX;
        return PULSE_BITS'(vw);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_accel  <= RST_ACCEL;
            r_decel  <= RST_DECEL;
            r_frs    <= '0;
            r_c0     <= RST_C0;
            r_cruise <= RST_CRUISE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:   r_mode   <= i_cfg_data[0];
                REG_ACCEL:  r_accel  <= i_cfg_data[RATE_BITS-1:0];
                REG_DECEL:  r_decel  <= i_cfg_data[RATE_BITS-1:0];
                REG_FRS:    r_frs    <= i_cfg_data[FRS_BITS-1:0];
                REG_C0:     r_c0     <= i_cfg_data[CFG_PUL_BITS-1:0];
                REG_CRUISE: r_cruise <= i_cfg_data[CFG_PUL_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign w_a = (r_accel == '0) ? RATE_BITS'(1) : r_accel;
    assign w_d = (r_decel == '0) ? RATE_BITS'(1) : r_decel;

    always_comb begin
        if (r_remaining == '0)
            w_st = MS_STOPPED;
        else if (r_remaining <= r_down)
            w_st = MS_DECEL;
        else if (r_taken <= r_up)
            w_st = MS_ACCEL;
        else
            w_st = MS_CRUISE;
    end

    // Magnitude of the signed move, saturated to the counter range.
    assign w_mag25 = i_move_steps[MOVE_BITS-1]
                   ? 25'(25'd0 - {1'b1, i_move_steps})
                   : {1'b0, i_move_steps};
    assign w_mag     = ({7'd0, w_mag25} > CNT_LIM) ? CNT_MAX : COUNT_BITS'(w_mag25);
    assign w_frs_sat = (32'(r_frs) > CNT_LIM) ? CNT_MAX : COUNT_BITS'(r_frs);

    assign w_mul_sum = (COUNT_BITS+1)'(r_mul_acc[COUNT_BITS+15:16])
                     + (r_mul_acc[0] ? (COUNT_BITS+1)'(r_mul_cand) : '0);

    // Recurrence numerator 2c + r, signed in NB+1 bits.
    assign w_num     = (NB+1)'({r_pulse, 1'b0}) + {{(NB+1-32){r_carry[31]}}, r_carry};
    assign w_num_mag = w_num[NB] ? NB'((NB+1)'(0) - w_num) : w_num[NB-1:0];

    srps_div #(
        .NB (NB),
        .DB (DB)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_div_go),
        .i_dividend  (r_div_n),
        .i_divisor   (r_div_d),
        .o_done      (w_div_done),
        .o_quotient  (w_quot),
        .o_remainder (w_rmd)
    );

    assign w_np_raw = (r_nneg ^ r_dneg)
                    ? (NB+2)'(r_pulse) + (NB+2)'(w_quot)
                    : (NB+2)'(r_pulse) - (NB+2)'(w_quot);

    always_comb begin
        if (w_np_raw[NB+1])
            w_np = '0;
        else if (w_np_raw > (NB+2)'(PUL_LIM))
            w_np = PUL_MAX;
        else
            w_np = PULSE_BITS'(w_np_raw);
    end

    assign w_q_sat = (w_quot > NB'(CNT_LIM)) ? CNT_MAX : COUNT_BITS'(w_quot);

    // The remainder takes the sign of the numerator; clamp to 32 bits signed.
    always_comb begin
        if (!r_nneg)
            w_rem_clamp = ({{(64-DB){1'b0}}, w_rmd} > 64'h7FFF_FFFF)
                        ? 32'h7FFF_FFFF : 32'(w_rmd);
        else
            w_rem_clamp = ({{(64-DB){1'b0}}, w_rmd} > 64'h8000_0000)
                        ? 32'h8000_0000 : 32'(64'd0 - {{(64-DB){1'b0}}, w_rmd});
    end

    assign w_sum33 = 33'(r_remaining) + 33'(w_mag);

    always_comb begin
        logic plan;
        plan           = 1'b0;
        n_state        = r_state;
        n_op           = r_op;
        n_remaining    = r_remaining;
        n_taken        = r_taken;
        n_up           = r_up;
        n_down         = r_down;
        n_pulse        = r_pulse;
        n_carry        = r_carry;
        n_dir          = r_dir;
        n_interval     = r_interval;
        n_issued       = r_issued;
        n_dropped      = r_dropped;
        n_mul_acc      = r_mul_acc;
        n_mul_cand     = r_mul_cand;
        n_cnt          = r_cnt;
        n_div_n        = r_div_n;
        n_div_d        = r_div_d;
        n_div_go       = 1'b0;
        n_nneg         = r_nneg;
        n_dneg         = r_dneg;
        n_out_valid    = r_out_valid && i_stall;
        n_out_interval = r_out_interval;
        n_out_issued   = r_out_issued;
        n_out_dir      = r_out_dir;
        n_out_ms       = r_out_ms;
        n_out_left     = r_out_left;
        n_out_dropped  = r_out_dropped;

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_interval = '0;
                    n_issued   = 1'b0;
                    n_dropped  = '0;
                    n_state    = ST_DONE;
                    case (i_func)
                        FN_START: plan = 1'b1;
                        FN_STEP: begin
                            if (r_remaining != '0) begin
                                n_interval  = r_pulse;
                                n_issued    = 1'b1;
                                n_remaining = r_remaining - COUNT_BITS'(1);
                                if (r_taken != CNT_MAX)
                                    n_taken = r_taken + COUNT_BITS'(1);
                                n_state = ST_ADV;
                            end
                        end
                        FN_ALTER: begin
                            if (w_st == MS_ACCEL || w_st == MS_CRUISE) begin
                                if (!i_move_steps[MOVE_BITS-1]) begin
                                    n_remaining = (w_sum33 > 33'(CNT_LIM))
                                                ? CNT_MAX : COUNT_BITS'(w_sum33);
                                end else if (33'(r_remaining) > 33'(r_down) + 33'(w_mag)) begin
                                    n_remaining = r_remaining - w_mag;
                                end else begin
                                    n_remaining = r_down;
                                end
                            end else if (w_st == MS_STOPPED) begin
                                plan = 1'b1;
                            end
                        end
                        FN_BRAKE: begin
                            if (w_st == MS_CRUISE) begin
                                n_remaining = r_down;
                            end else if (w_st == MS_ACCEL) begin
                                n_op       = OP_BRAKE;
                                n_mul_acc  = {COUNT_BITS'(0), w_a};
                                n_mul_cand = r_taken;
                                n_cnt      = MUL_STEPS;
                                n_state    = ST_MUL;
                            end
                        end
                        FN_STOP: begin
                            n_dropped   = r_remaining;
                            n_remaining = '0;
                        end
                        default: ;
                    endcase
                    if (plan) begin
                        n_dir       = !i_move_steps[MOVE_BITS-1];
                        n_remaining = w_mag;
                        n_taken     = '0;
                        n_carry     = '0;
                        if (r_mode) begin
                            n_up       = w_frs_sat;
                            n_pulse    = sat_pul(r_c0);
                            n_op       = OP_PLAN1;
                            n_mul_acc  = {COUNT_BITS'(0), w_a};
                            n_mul_cand = w_frs_sat;
                            n_cnt      = MUL_STEPS;
                            n_state    = ST_MUL;
                        end else begin
                            n_up    = '0;
                            n_down  = '0;
                            n_pulse = sat_pul(r_cruise);
                        end
                    end
                end
            end
            ST_MUL: begin
                if (r_cnt != '0) begin
                    n_mul_acc = {w_mul_sum, r_mul_acc[15:1]};
                    n_cnt     = r_cnt - 5'd1;
                end else begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_div_go = 1'b1;
                n_state  = ST_DIV;
                if (r_op == OP_REC1 || r_op == OP_REC2) begin
                    n_div_n = w_num_mag;
                    n_nneg  = w_num[NB];
                end else begin
                    n_div_n = NB'(r_mul_acc);
                    n_nneg  = 1'b0;
                    n_dneg  = 1'b0;
                    n_div_d = (r_op == OP_PLAN2)
                            ? DB'(17'(w_a) + 17'(w_d)) : DB'(w_d);
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    case (r_op)
                        OP_PLAN1: begin
                            n_down  = w_q_sat;
                            n_state = ST_DONE;
                            // A short move shares its length between the ramps.
                            if ((COUNT_BITS+1)'(r_remaining)
                                    < (COUNT_BITS+1)'(r_up) + (COUNT_BITS+1)'(w_q_sat)) begin
                                n_op       = OP_PLAN2;
                                n_mul_acc  = {COUNT_BITS'(0), w_d};
                                n_mul_cand = r_remaining;
                                n_cnt      = MUL_STEPS;
                                n_state    = ST_MUL;
                            end
                        end
                        OP_PLAN2: begin
                            n_up    = COUNT_BITS'(w_quot);
                            n_down  = r_remaining - COUNT_BITS'(w_quot);
                            n_state = ST_DONE;
                        end
                        OP_BRAKE: begin
                            n_remaining = w_q_sat;
                            n_state     = ST_DONE;
                        end
                        OP_REC1: begin
                            n_pulse = w_np;
                            n_op    = OP_REC2;
                            n_state = ST_LOAD;
                        end
                        OP_REC2: begin
                            n_carry = w_rem_clamp;
                            n_state = ST_DONE;
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_ADV: begin
                n_state = ST_DONE;
                if (r_mode) begin
                    if (w_st == MS_ACCEL) begin
                        if (r_taken < r_up) begin
                            n_div_d = DB'({r_taken, 2'b01});
                            n_dneg  = 1'b0;
                            n_op    = OP_REC1;
                            n_state = ST_LOAD;
                        end else begin
                            n_pulse = sat_pul(r_cruise);
                        end
                    end else if (w_st == MS_DECEL) begin
                        // Braking divides by 1 - 4m, held here as its magnitude.
                        n_div_d = DB'({r_remaining, 2'b00}) - DB'(1);
                        n_dneg  = 1'b1;
                        n_op    = OP_REC1;
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid    = 1'b1;
                    n_out_interval = r_interval;
                    n_out_issued   = r_issued;
                    n_out_dir      = r_dir;
                    n_out_ms       = w_st;
                    n_out_left     = r_remaining;
                    n_out_dropped  = r_dropped;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_PLAN1;
            r_remaining <= '0;
            r_taken     <= '0;
            r_up        <= '0;
            r_down      <= '0;
            r_pulse     <= '0;
            r_carry     <= '0;
            r_dir       <= 1'b0;
            r_cnt       <= '0;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_remaining <= n_remaining;
            r_taken     <= n_taken;
            r_up        <= n_up;
            r_down      <= n_down;
            r_pulse     <= n_pulse;
            r_carry     <= n_carry;
            r_dir       <= n_dir;
            r_cnt       <= n_cnt;
            r_div_go    <= n_div_go;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_interval     <= n_interval;
        r_issued       <= n_issued;
        r_dropped      <= n_dropped;
        r_mul_acc      <= n_mul_acc;
        r_mul_cand     <= n_mul_cand;
        r_div_n        <= n_div_n;
        r_div_d        <= n_div_d;
        r_nneg         <= n_nneg;
        r_dneg         <= n_dneg;
        r_out_interval <= n_out_interval;
        r_out_issued   <= n_out_issued;
        r_out_dir      <= n_out_dir;
        r_out_ms       <= n_out_ms;
        r_out_left     <= n_out_left;
        r_out_dropped  <= n_out_dropped;
    end

    assign o_stall         = (r_state != ST_IDLE);
    assign o_valid         = r_out_valid;
    assign o_interval      = r_out_interval;
    assign o_step_issued   = r_out_issued;
    assign o_direction     = r_out_dir;
    assign o_motion_state  = r_out_ms;
    assign o_steps_left    = r_out_left;
    assign o_steps_dropped = r_out_dropped;

    `SRPS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_valid && !o_stall, r_state != ST_IDLE)
    `SRPS_ASSERT_NOW(a_no_step_no_interval, i_clk, i_rst_n, o_valid && !o_step_issued, o_interval == '0)
    `SRPS_ASSERT_NOW(a_stopped_iff_empty, i_clk, i_rst_n, o_valid, (o_steps_left == '0) == (o_motion_state == MS_STOPPED))
    `SRPS_ASSERT_NOW(a_div_done_in_div, i_clk, i_rst_n, w_div_done, r_state == ST_DIV)

endmodule

// ===== sim/srps_checker.sv =====
// Scoreboard that predicts and checks every output word of the stepper ramp scheduler.
`timescale 1ns / 1ps

module srps_checker import srps_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [2:0]                i_func,
    input  logic [MOVE_BITS-1:0]      i_move_steps,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [PULSE_BITS_DEF-1:0] i_interval,
    input  logic                      i_step_issued,
    input  logic                      i_direction,
    input  logic [1:0]                i_motion_state,
    input  logic [COUNT_BITS_DEF-1:0] i_steps_left,
    input  logic [COUNT_BITS_DEF-1:0] i_steps_dropped,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);

    localparam longint CNT_MAX = (64'd1 << COUNT_BITS_DEF) - 1;
    localparam longint PUL_MAX = (64'd1 << PULSE_BITS_DEF) - 1;
    localparam longint I32_MAX = 64'sd2147483647;
    localparam longint I32_MIN = -64'sd2147483648;

    typedef struct {
        logic [PULSE_BITS_DEF-1:0] interval;
        logic                      issued;
        logic                      dir;
        t_mstate                   mstate;
        logic [COUNT_BITS_DEF-1:0] left;
        logic [COUNT_BITS_DEF-1:0] dropped;
    } t_motion_word;

    t_motion_word expected_words[$];

    // Shadow configuration and motion state.
    longint ramp_mode, acc_rate, dec_rate, ramp_len, start_pulse, cruise_iv;
    longint left_cnt, done_cnt, up_cnt, down_cnt, cur_pulse, carry;
    logic   fwd;

    function automatic longint sat_count(longint v);
        return (v > CNT_MAX) ? CNT_MAX : v;
    endfunction

    function automatic longint non_zero(longint v);
        return (v == 0) ? 1 : v;
    endfunction

    function t_mstate motion_phase();
        if (left_cnt == 0) return MS_STOPPED;
        if (left_cnt <= down_cnt) return MS_DECEL;
        if (done_cnt <= up_cnt) return MS_ACCEL;
        return MS_CRUISE;
    endfunction

    task plan_move(input logic [MOVE_BITS-1:0] raw);
        longint a, d, mag;
        a = non_zero(acc_rate);
        d = non_zero(dec_rate);
        mag = raw;
        if (raw[MOVE_BITS-1]) mag = (64'd1 << MOVE_BITS) - mag;
        fwd = !raw[MOVE_BITS-1];
        left_cnt = sat_count(mag);
        done_cnt = 0;
        carry = 0;
        if (ramp_mode == 1) begin
            up_cnt = sat_count(ramp_len);
            down_cnt = sat_count(up_cnt * a / d);
            // A move too short for the full ramp is split in proportion to the rates.
            if (left_cnt < up_cnt + down_cnt) begin
                up_cnt = left_cnt * d / (a + d);
                down_cnt = left_cnt - up_cnt;
            end
            cur_pulse = start_pulse;
        end else begin
            up_cnt = 0;
            down_cnt = 0;
            cur_pulse = cruise_iv;
        end
    endtask

    task austin_update(input longint div);
        longint num, np, r;
        num = 2 * cur_pulse + carry;
        np = cur_pulse - num / div;
        if (np < 0) np = 0;
        if (np > PUL_MAX) np = PUL_MAX;
        r = (2 * np + carry) % div;
        carry = (r > I32_MAX) ? I32_MAX : (r < I32_MIN) ? I32_MIN : r;
        cur_pulse = np;
    endtask

    task take_step();
        t_mstate ph;
        left_cnt = left_cnt - 1;
        if (done_cnt < CNT_MAX) done_cnt = done_cnt + 1;
        if (ramp_mode == 1) begin
            ph = motion_phase();
            if (ph == MS_ACCEL) begin
                if (done_cnt < up_cnt) austin_update(4 * done_cnt + 1);
                else cur_pulse = cruise_iv;
            end else if (ph == MS_DECEL) begin
                austin_update(1 - 4 * left_cnt);
            end
        end
    endtask

    task predict_word(input logic [2:0] fn, input logic [MOVE_BITS-1:0] raw);
        t_motion_word w;
        t_mstate      ph;
        longint       s, r;
        w.interval = '0;
        w.issued = 1'b0;
        w.dropped = '0;
        ph = motion_phase();
        case (fn)
            FN_START: plan_move(raw);
            FN_STEP: begin
                if (left_cnt > 0) begin
                    w.interval = cur_pulse[PULSE_BITS_DEF-1:0];
                    w.issued = 1'b1;
                    take_step();
                end
            end
            FN_ALTER: begin
                if (ph == MS_ACCEL || ph == MS_CRUISE) begin
                    s = $signed(raw);
                    if (s >= 0) begin
                        left_cnt = sat_count(left_cnt + s);
                    end else begin
                        r = left_cnt + s;
                        left_cnt = (r > down_cnt) ? r : down_cnt;
                    end
                end else if (ph == MS_STOPPED) begin
                    plan_move(raw);
                end
            end
            FN_BRAKE: begin
                if (ph == MS_CRUISE) left_cnt = down_cnt;
                else if (ph == MS_ACCEL)
                    left_cnt = sat_count(done_cnt * non_zero(acc_rate) / non_zero(dec_rate));
            end
            FN_STOP: begin
                w.dropped = left_cnt[COUNT_BITS_DEF-1:0];
                left_cnt = 0;
            end
            default: ;
        endcase
        w.dir = fwd;
        w.mstate = motion_phase();
        w.left = left_cnt[COUNT_BITS_DEF-1:0];
        expected_words.push_back(w);
    endtask

    task report(input string what, input longint exp_v, input longint act_v);
        if (o_fail_count < 10)
            $display("mismatch on %s: expected %0d, got %0d", what, exp_v, act_v);
        o_fail_count = o_fail_count + 1;
    endtask

    always @(posedge i_clk) begin
        t_motion_word w;
        if (!i_rst_n) begin
            ramp_mode = 0;  acc_rate = RST_ACCEL;  dec_rate = RST_DECEL;
            ramp_len = 0;  start_pulse = RST_C0;  cruise_iv = RST_CRUISE;
            left_cnt = 0;  done_cnt = 0;  up_cnt = 0;  down_cnt = 0;
            cur_pulse = 0;  carry = 0;  fwd = 1'b0;
            expected_words.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    report("unexpected word", 0, 1);
                end else begin
                    w = expected_words.pop_front();
                    if (i_interval !== w.interval) report("interval", w.interval, i_interval);
                    if (i_step_issued !== w.issued) report("step_issued", w.issued, i_step_issued);
                    if (i_direction !== w.dir) report("direction", w.dir, i_direction);
                    if (i_motion_state !== w.mstate)
                        report("motion_state", w.mstate, i_motion_state);
                    if (i_steps_left !== w.left) report("steps_left", w.left, i_steps_left);
                    if (i_steps_dropped !== w.dropped)
                        report("steps_dropped", w.dropped, i_steps_dropped);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MODE:   ramp_mode = i_cfg_data[0];
                    REG_ACCEL:  acc_rate = i_cfg_data[RATE_BITS-1:0];
                    REG_DECEL:  dec_rate = i_cfg_data[RATE_BITS-1:0];
                    REG_FRS:    ramp_len = i_cfg_data[FRS_BITS-1:0];
                    REG_C0:     start_pulse = i_cfg_data;
                    REG_CRUISE: cruise_iv = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) predict_word(i_func, i_move_steps);
        end
        o_pending = expected_words.size();
    end

endmodule

// ===== sim/tb.sv =====
// Top of the stepper ramp scheduler testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb import srps_pkg::*;;

    localparam int LIMIT_CYCLES = 3000000;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic [2:0]                i_func = FN_STOP;
    logic [MOVE_BITS-1:0]      i_move_steps = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b1;
    logic [PULSE_BITS_DEF-1:0] o_interval;
    logic                      o_step_issued;
    logic                      o_direction;
    logic [1:0]                o_motion_state;
    logic [COUNT_BITS_DEF-1:0] o_steps_left;
    logic [COUNT_BITS_DEF-1:0] o_steps_dropped;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]   i_cfg_idx = REG_MODE;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data = '0;

    int  fail_count;
    int  pending;
    int  cycles = 0;
    int  words_sent = 0;
    int  words_back = 0;
    bit  quiet = 1'b0;

    always #5 i_clk = ~i_clk;

    stepper_ramp_pulse_scheduler dut (.*);

    srps_checker checker_inst (
        .i_clk, .i_rst_n,
        .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_func, .i_move_steps,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_interval(o_interval), .i_step_issued(o_step_issued),
        .i_direction(o_direction), .i_motion_state(o_motion_state),
        .i_steps_left(o_steps_left), .i_steps_dropped(o_steps_dropped),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: random stalls, and one long hold-off so that the block backs up.
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            n = quiet ? 0 : $urandom_range(0, 16);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            words_back++;
            if (words_back == 300) begin
                i_stall <= 1'b1;
                repeat (4000) @(posedge i_clk);
            end
        end
    end

    task send_word(input logic [2:0] fn, input logic [MOVE_BITS-1:0] mv);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= fn;
        i_move_steps <= mv;
        do @(posedge i_clk); while (o_stall);
        words_sent++;
    endtask

    task write_reg(input t_cfg_reg idx, input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Drain every outstanding word, then let the block settle before reconfiguring.
    task drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task configure(input logic md, input logic [15:0] a, input logic [15:0] d,
                   input logic [22:0] frs, input logic [23:0] c0, input logic [23:0] cr);
        write_reg(REG_MODE, CFG_DATA_BITS'(md));
        write_reg(REG_ACCEL, CFG_DATA_BITS'(a));
        write_reg(REG_DECEL, CFG_DATA_BITS'(d));
        write_reg(REG_FRS, CFG_DATA_BITS'(frs));
        write_reg(REG_C0, c0);
        write_reg(REG_CRUISE, cr);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_rate();
        case ($urandom_range(0, 5))
            0: return 16'd1;
            1: return 16'hFFFF;
            2: return 16'd0;
            default: return 16'($urandom_range(1, 4000));
        endcase
    endfunction

    function automatic logic [23:0] pick_pulse();
        case ($urandom_range(0, 5))
            0: return 24'd1;
            1: return 24'hFFFFFF;
            default: return 24'($urandom_range(50, 200000));
        endcase
    endfunction

    function automatic logic [MOVE_BITS-1:0] pick_move();
        int m;
        if ($urandom_range(0, 15) == 0) return MOVE_BITS'($urandom);
        m = $urandom_range(1, 120);
        return $urandom_range(0, 1) ? MOVE_BITS'(-m) : MOVE_BITS'(m);
    endfunction

    // One well-formed move with random content, sprinkled with other commands.
    task run_move();
        int steps;
        send_word(FN_START, pick_move());
        steps = $urandom_range(1, 130);
        repeat (steps) begin
            case ($urandom_range(0, 39))
                0: send_word(FN_ALTER, pick_move());
                1: send_word(FN_BRAKE, MOVE_BITS'($urandom));
                2: send_word(FN_STOP, MOVE_BITS'($urandom));
                3: send_word(3'($urandom_range(5, 7)), MOVE_BITS'($urandom));
                4: send_word(3'($urandom), MOVE_BITS'($urandom));
                default: send_word(FN_STEP, MOVE_BITS'($urandom));
            endcase
        end
    endtask

    initial begin
        int target;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every command and the corner cases.
        configure(1'b1, 16'd1000, 16'd500, 23'd20, 24'd5000, 24'd800);
        send_word(FN_STEP, '0);
        send_word(FN_BRAKE, '0);
        send_word(FN_ALTER, MOVE_BITS'(-60));
        repeat (3) send_word(FN_STEP, '0);
        send_word(FN_ALTER, MOVE_BITS'(40));
        send_word(FN_BRAKE, '0);
        send_word(FN_ALTER, MOVE_BITS'(5));
        repeat (4) send_word(FN_STEP, '0);
        send_word(3'd5, 24'hFFFFFF);
        send_word(3'd6, '0);
        send_word(3'd7, 24'h800000);
        send_word(FN_STOP, '0);
        send_word(FN_START, 24'h800000);
        send_word(FN_STEP, '0);
        send_word(FN_ALTER, 24'h7FFFFF);
        send_word(FN_STOP, '0);
        send_word(FN_START, 24'h7FFFFF);
        repeat (2) send_word(FN_STEP, '0);
        send_word(FN_ALTER, 24'h800000);
        send_word(FN_STOP, '0);
        drain();

        configure(1'b1, 16'd0, 16'd0, 23'h7FFFFF, 24'hFFFFFF, 24'd1);
        send_word(FN_START, MOVE_BITS'(9));
        repeat (10) send_word(FN_STEP, '0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            quiet = (ph == 3);
            configure(ph == 0 ? 1'b0 : 1'($urandom_range(0, 3) != 0),
                      pick_rate(), pick_rate(),
                      ph == 5 ? 23'h7FFFFF : 23'($urandom_range(0, 60)),
                      pick_pulse(), pick_pulse());
            target = words_sent + 225;
            while (words_sent < target) run_move();
            drain();
        end
        quiet = 1'b0;

        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/srps_pkg.sv
hw/rtl/srps_div.sv
hw/rtl/stepper_ramp_pulse_scheduler.sv
sim/srps_checker.sv
sim/tb.sv
